[src/gsf_pkg.sv]
package gsf_pkg;

    // Widest image row the line stores are sized for.
    localparam int GSF_MAX_WIDTH = 2048;

    // Height limit applied to the height register.
    localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

    // Reset values of the configuration registers.
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    // Filter modes.
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_GAUSS = 2'd1;
    localparam logic [1:0] MODE_SOBEL = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Input operation codes.
    localparam logic OP_PIXEL = 1'b0;

    // Depth of the output queue; it also bounds the items in flight.
    localparam int QUEUE_DEPTH = 16;

    // 5x5 Gaussian kernel, weights sum to 273.
    localparam logic [5:0] GAUSS_KERNEL [5][5] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };

    // Division by 273 as multiplication by ceil(2^25 / 273) and a shift.
    // The product is exact for every sum below 2^25 / 271.
    localparam logic [16:0] GAUSS_RECIP = 17'd122911;
    localparam int          GAUSS_SHIFT = 25;

    // What the last pipeline stage hands to the output queue.
    typedef struct packed {
        logic        push;
        logic [1:0]  mode;
        logic        last;
        logic [23:0] copy_px;
        logic [23:0] gauss_px;
        logic [23:0] sobel_px;
    } merge_in_t;

endpackage

[src/gsf_gauss_lane.sv]
module gsf_gauss_lane
    import gsf_pkg::*;
(
    input  logic       clk,
    input  logic [7:0] taps [25],
    output logic [7:0] result
);

    logic [16:0] row_sum [5];
    logic [16:0] row_sum_reg [5];
    logic [16:0] total_reg;
    logic [33:0] prod_reg;

    // Weighted sum of each window row.
    always_comb
    begin
        for (int s = 0; s < 5; s++)
        begin
            row_sum[s] = '0;
            for (int t = 0; t < 5; t++)
            begin
                row_sum[s] = row_sum[s]
                    + 17'(taps[s * 5 + t]) * 17'(GAUSS_KERNEL[s][t]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum;
        total_reg   <= row_sum_reg[0] + row_sum_reg[1] + row_sum_reg[2]
                       + row_sum_reg[3] + row_sum_reg[4];
        prod_reg    <= 34'(total_reg) * 34'(GAUSS_RECIP);
    end

    assign result = prod_reg[GAUSS_SHIFT +: 8];

endmodule

[src/gsf_sobel_lane.sv]
module gsf_sobel_lane
    import gsf_pkg::*;
(
    input  logic       clk,
    input  logic [7:0] taps [9],
    output logic [7:0] result
);

    logic [10:0]        gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [11:0] gx_reg, gy_reg;
    logic [10:0]        gx_abs, gy_abs;
    logic [11:0]        mag;

    // Positive and negative halves of both masks.
    always_comb
    begin
        gx_pos = 11'(taps[0]) + {2'b0, taps[1], 1'b0} + 11'(taps[2]);
        gx_neg = 11'(taps[6]) + {2'b0, taps[7], 1'b0} + 11'(taps[8]);
        gy_pos = 11'(taps[2]) + {2'b0, taps[5], 1'b0} + 11'(taps[8]);
        gy_neg = 11'(taps[0]) + {2'b0, taps[3], 1'b0} + 11'(taps[6]);
    end

    always_ff @(posedge clk)
    begin
        gx_reg <= signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
        gy_reg <= signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
    end

    always_comb
    begin
        gx_abs = gx_reg[11] ? 11'(-gx_reg) : gx_reg[10:0];
        gy_abs = gy_reg[11] ? 11'(-gy_reg) : gy_reg[10:0];
        mag    = 12'(gx_abs) + 12'(gy_abs);
    end

    assign result = mag[10:3];

endmodule

[src/gsf_out_queue.sv]
module gsf_out_queue
    import gsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  merge_in_t  merge_in,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_chan0,
    output logic [7:0] out_chan1,
    output logic [7:0] out_chan2,
    output logic       last_pixel
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [24:0]   entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   sel_px;
    logic          pop;

    // Pick the result of the active filter.
    always_comb
    begin
        case (merge_in.mode)
            MODE_GAUSS: sel_px = merge_in.gauss_px;
            MODE_SOBEL: sel_px = merge_in.sobel_px;
            default:    sel_px = merge_in.copy_px;
        endcase
    end

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (merge_in.push)
        begin
            tail_next = (32'(tail_reg) == QUEUE_DEPTH - 1) ? '0 : tail_reg + PW'(1);
        end
        if (pop)
        begin
            head_next = (32'(head_reg) == QUEUE_DEPTH - 1) ? '0 : head_reg + PW'(1);
        end
        count_next = count_reg + CW'(merge_in.push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge_in.push)
        begin
            entry_reg[tail_reg] <= {merge_in.last, sel_px};
        end
    end

    assign out_valid  = (count_reg != '0);
    assign out_chan0  = entry_reg[head_reg][7:0];
    assign out_chan1  = entry_reg[head_reg][15:8];
    assign out_chan2  = entry_reg[head_reg][23:16];
    assign last_pixel = entry_reg[head_reg][24];

endmodule

[src/gauss_sobel_pixel_filter.sv]
// Streaming pixel filter: copy, 5x5 Gaussian blur, or blur followed by a
// 3x3 Sobel edge magnitude, applied to each 8-bit channel on its own.
// Pixels enter on the in channel (in_valid / in_stall) in raster order; a
// transfer with operation set is a drain item that pushes the window on
// after the last pixel of the frame (2W+2 of them in blur mode, 3W+3 in
// edge mode). Results leave on the out channel (out_valid / out_stall) in
// the same order, with last_pixel marking the final pixel of the frame.
// Configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle; every write restarts the frame.
// One transfer is taken per clock while in_stall is low. A result reaches
// out_valid once the input transfer that completes it has passed the
// blur, divide, edge and merge pipeline. Blur results trail the input by
// 2W+2 items and edge results by 3W+3 items, held in the line stores.
// The output queue is 16 deep and the occupancy count also covers items
// still in the pipeline, so in_stall rises only when the receiver holds
// out_stall long enough for pipeline and queue together to fill; nothing
// is lost or repeated. Reset loads the configuration reset values and
// clears the positions and the queue; line stores are not cleared.
module gauss_sobel_pixel_filter
    import gsf_pkg::*;
#(
    parameter int MAX_WIDTH = GSF_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  chan0,
    input  logic [7:0]  chan1,
    input  logic [7:0]  chan2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_chan0,
    output logic [7:0]  out_chan1,
    output logic [7:0]  out_chan2,
    output logic        last_pixel
);

    // Column index width, and width of a value that can hold MAX_WIDTH.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = WW + 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    // Control carried alongside each item down the pipeline.
    typedef struct packed {
        logic          valid;
        logic          emit;
        logic          last;
        logic          gadv;
        logic [1:0]    mode;
        logic [23:0]   px;
        logic [CW-1:0] baddr;
        logic [CW-1:0] eaddr;
        logic [4:0]    grow;
        logic [4:0]    gcol;
        logic [2:0]    srow;
        logic [2:0]    scol;
        logic [23:0]   gval;
    } ctl_t;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    // Stream positions: the input item, the blur center and the output.
    logic [23:0]   p_reg, p_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [12:0]   in_row_reg, in_row_next;
    logic [CW-1:0] gc_col_reg, gc_col_next;
    logic [12:0]   gc_row_reg, gc_row_next;
    logic [CW-1:0] oc_col_reg, oc_col_next;
    logic [12:0]   oc_row_reg, oc_row_next;

    logic [WW-1:0] weff;
    logic [12:0]   heff;
    logic [1:0]    mode_eff;
    logic [23:0]   w24, glat, lat;
    logic          acc;
    ctl_t          s0;
    ctl_t          st_reg [1:8];

    // Line stores: four delayed rows of input, two delayed rows of blur.
    logic [95:0] blur_mem_reg [MAX_WIDTH];
    logic [95:0] blur_rd_reg;
    logic [95:0] blur_wr;
    logic [47:0] edge_mem_reg [MAX_WIDTH];
    logic [47:0] edge_rd_reg;
    logic [47:0] edge_wr;

    logic [23:0] bwin_reg [5][5];
    logic [23:0] ewin_reg [3][3];

    logic [7:0]  gtap [3][25];
    logic [7:0]  stap [3][9];
    logic [7:0]  gres [3];
    logic [7:0]  sres [3];
    merge_in_t   merge_in;

    logic [OW-1:0] occ_reg, occ_next;
    logic          drop, pop;

    // Effective geometry and mode; out of range values are clamped.
    always_comb
    begin
        if (width_reg == '0)
            weff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            weff = WW'(MAX_WIDTH);
        else
            weff = WW'(width_reg);

        if (height_reg == '0)
            heff = 13'd1;
        else if (height_reg > HEIGHT_LIMIT)
            heff = HEIGHT_LIMIT;
        else
            heff = height_reg;

        if (mode_reg == MODE_GAUSS || mode_reg == MODE_SOBEL)
            mode_eff = mode_reg;
        else
            mode_eff = MODE_COPY;

        w24  = 24'(weff);
        glat = {w24[22:0], 1'b0} + 24'd2;
        case (mode_eff)
            MODE_GAUSS: lat = glat;
            MODE_SOBEL: lat = glat + w24 + 24'd1;
            default:    lat = '0;
        endcase
    end

    assign in_stall = (32'(occ_reg) >= QUEUE_DEPTH);
    assign acc      = in_valid && !in_stall;

    // Front stage: decide what this item does and where its window sits.
    always_comb
    begin
        s0       = '0;
        s0.valid = acc;
        s0.mode  = mode_eff;
        if (operation == OP_PIXEL && in_row_reg < heff)
            s0.px = {chan2, chan1, chan0};
        s0.emit  = (p_reg >= lat);
        s0.gadv  = (mode_eff != MODE_COPY) && (p_reg >= glat);
        s0.last  = s0.emit && (oc_row_reg == heff - 13'd1)
                   && (WW'(oc_col_reg) == weff - WW'(1));
        s0.baddr = in_col_reg;
        s0.eaddr = gc_col_reg;

        s0.gcol[0] = (XW'(gc_col_reg) >= XW'(2));
        s0.gcol[1] = (XW'(gc_col_reg) >= XW'(1));
        s0.gcol[2] = 1'b1;
        s0.gcol[3] = (XW'(gc_col_reg) + XW'(1) < XW'(weff));
        s0.gcol[4] = (XW'(gc_col_reg) + XW'(2) < XW'(weff));
        s0.grow[0] = (gc_row_reg >= 13'd2);
        s0.grow[1] = (gc_row_reg >= 13'd1);
        s0.grow[2] = (gc_row_reg < heff);
        s0.grow[3] = (14'(gc_row_reg) + 14'd1 < 14'(heff));
        s0.grow[4] = (14'(gc_row_reg) + 14'd2 < 14'(heff));

        s0.scol[0] = (oc_col_reg != '0);
        s0.scol[1] = 1'b1;
        s0.scol[2] = (XW'(oc_col_reg) + XW'(1) < XW'(weff));
        s0.srow[0] = (oc_row_reg != '0);
        s0.srow[1] = 1'b1;
        s0.srow[2] = (14'(oc_row_reg) + 14'd1 < 14'(heff));
    end

    // Position counters. A finished frame or any register write restarts.
    always_comb
    begin
        p_next      = p_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        gc_col_next = gc_col_reg;
        gc_row_next = gc_row_reg;
        oc_col_next = oc_col_reg;
        oc_row_next = oc_row_reg;
        if (cfg_we || (acc && s0.last))
        begin
            p_next      = '0;
            in_col_next = '0;
            in_row_next = '0;
            gc_col_next = '0;
            gc_row_next = '0;
            oc_col_next = '0;
            oc_row_next = '0;
        end
        else if (acc)
        begin
            p_next = p_reg + 24'd1;
            if (WW'(in_col_reg) == weff - WW'(1))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 13'd1;
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (s0.gadv)
            begin
                if (WW'(gc_col_reg) == weff - WW'(1))
                begin
                    gc_col_next = '0;
                    gc_row_next = gc_row_reg + 13'd1;
                end
                else
                begin
                    gc_col_next = gc_col_reg + CW'(1);
                end
            end
            if (s0.emit)
            begin
                if (WW'(oc_col_reg) == weff - WW'(1))
                begin
                    oc_col_next = '0;
                    oc_row_next = oc_row_reg + 13'd1;
                end
                else
                begin
                    oc_col_next = oc_col_reg + CW'(1);
                end
            end
        end
    end

    // Items in the pipeline plus results in the queue.
    assign drop     = st_reg[8].valid && !st_reg[8].emit;
    assign pop      = out_valid && !out_stall;
    assign occ_next = occ_reg + OW'(acc) - OW'(drop) - OW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_COPY;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            p_reg      <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
            gc_col_reg <= '0;
            gc_row_reg <= '0;
            oc_col_reg <= '0;
            oc_row_reg <= '0;
            occ_reg    <= '0;
            for (int k = 1; k <= 8; k++)
            begin
                st_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[11:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            p_reg      <= p_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            gc_col_reg <= gc_col_next;
            gc_row_reg <= gc_row_next;
            oc_col_reg <= oc_col_next;
            oc_row_reg <= oc_row_next;
            occ_reg    <= occ_next;
            st_reg[1]  <= s0;
            for (int k = 2; k <= 8; k++)
            begin
                st_reg[k] <= st_reg[k - 1];
            end
            // The blur result joins its item as it leaves the divider.
            st_reg[6].gval <= {gres[2], gres[1], gres[0]};
        end
    end

    // Input line store: read on transfer, written back in the next cycle with
    // the rows moved down by one. A write to the address being read is
    // forwarded, which covers one-pixel-wide images.
    assign blur_wr = {blur_rd_reg[71:0], st_reg[1].px};

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            if (st_reg[1].valid && st_reg[1].baddr == in_col_reg)
                blur_rd_reg <= blur_wr;
            else
                blur_rd_reg <= blur_mem_reg[in_col_reg];
        end
        if (st_reg[1].valid)
        begin
            blur_mem_reg[st_reg[1].baddr] <= blur_wr;
        end
    end

    // 5x5 window: the newest column enters on the right, bottom row newest.
    always_ff @(posedge clk)
    begin
        if (st_reg[1].valid)
        begin
            for (int s = 0; s < 5; s++)
            begin
                for (int t = 0; t < 4; t++)
                begin
                    bwin_reg[s][t] <= bwin_reg[s][t + 1];
                end
            end
            bwin_reg[4][4] <= st_reg[1].px;
            bwin_reg[3][4] <= blur_rd_reg[23:0];
            bwin_reg[2][4] <= blur_rd_reg[47:24];
            bwin_reg[1][4] <= blur_rd_reg[71:48];
            bwin_reg[0][4] <= blur_rd_reg[95:72];
        end
    end

    // Taps outside the image read as zero.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int s = 0; s < 5; s++)
            begin
                for (int t = 0; t < 5; t++)
                begin
                    gtap[c][s * 5 + t] = (st_reg[2].grow[s] && st_reg[2].gcol[t])
                                         ? bwin_reg[s][t][8 * c +: 8] : 8'd0;
                end
            end
        end
    end

    // One blur lane and one edge lane per channel.
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        gsf_gauss_lane u_gauss (
            .clk    (clk),
            .taps   (gtap[c]),
            .result (gres[c])
        );
        gsf_sobel_lane u_sobel (
            .clk    (clk),
            .taps   (stap[c]),
            .result (sres[c])
        );
    end

    // Blur line store, same scheme as the input store with two rows.
    assign edge_wr = {edge_rd_reg[23:0], st_reg[6].gval};

    always_ff @(posedge clk)
    begin
        if (st_reg[5].valid && st_reg[5].gadv)
        begin
            if (st_reg[6].valid && st_reg[6].gadv
                && st_reg[6].eaddr == st_reg[5].eaddr)
                edge_rd_reg <= edge_wr;
            else
                edge_rd_reg <= edge_mem_reg[st_reg[5].eaddr];
        end
        if (st_reg[6].valid && st_reg[6].gadv)
        begin
            edge_mem_reg[st_reg[6].eaddr] <= edge_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg[6].valid && st_reg[6].gadv)
        begin
            for (int s = 0; s < 3; s++)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    ewin_reg[s][t] <= ewin_reg[s][t + 1];
                end
            end
            ewin_reg[2][2] <= st_reg[6].gval;
            ewin_reg[1][2] <= edge_rd_reg[23:0];
            ewin_reg[0][2] <= edge_rd_reg[47:24];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                for (int t = 0; t < 3; t++)
                begin
                    stap[c][s * 3 + t] = (st_reg[7].srow[s] && st_reg[7].scol[t])
                                         ? ewin_reg[s][t][8 * c +: 8] : 8'd0;
                end
            end
        end
    end

    // Merge the lanes and queue the result.
    always_comb
    begin
        merge_in.push     = st_reg[8].valid && st_reg[8].emit;
        merge_in.mode     = st_reg[8].mode;
        merge_in.last     = st_reg[8].last;
        merge_in.copy_px  = st_reg[8].px;
        merge_in.gauss_px = st_reg[8].gval;
        merge_in.sobel_px = {sres[2], sres[1], sres[0]};
    end

    gsf_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .merge_in   (merge_in),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_chan0  (out_chan0),
        .out_chan1  (out_chan1),
        .out_chan2  (out_chan2),
        .last_pixel (last_pixel)
    );

endmodule

[src/gsf_checker.sv]
module gsf_checker
    import gsf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [12:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic        operation,
    input logic [7:0]  chan0,
    input logic [7:0]  chan1,
    input logic [7:0]  chan2,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_chan0,
    input logic [7:0]  out_chan1,
    input logic [7:0]  out_chan2,
    input logic        last_pixel
);

    // Coming out of reset nothing is queued and input is open.
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("block not idle after reset");

    // A result on an empty output comes from an input transfer that has passed the whole pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 9))
        else $error("result appeared without a matching input transfer");

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_chan0)
            && $stable(out_chan1) && $stable(out_chan2) && $stable(last_pixel))
        else $error("stalled result changed");

endmodule

bind gauss_sobel_pixel_filter gsf_checker u_checker (.*);
